[rtl/utf8_to_utf16_stream_decoder_unit_assert.svh]
// assertion macros for the utf-8 to utf-16 decoder checker
// no dependencies; included by the checker file only
`ifndef UTF8_TO_UTF16_STREAM_DECODER_UNIT_ASSERT_SVH
`define UTF8_TO_UTF16_STREAM_DECODER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define U8U16_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("u8u16 assertion failed");

// next-cycle implication, disabled during reset
`define U8U16_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("u8u16 assertion failed");

`endif

[rtl/u8u16_pkg.sv]
// shared types and constants of the utf-8 to utf-16 decoder
// no dependencies
package u8u16_pkg;

    localparam logic [15:0] UNDERSCORE  = 16'h005F;
    localparam int          QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_TWO    = 3'd1,
        PH_THREE1 = 3'd2,
        PH_THREE2 = 3'd3,
        PH_SKIP   = 3'd4
    } t_phase;

    // results of one input byte, one or two code units
    typedef struct packed {
        logic        two;
        logic        fin;
        logic [15:0] unit0;
        logic        repl0;
        logic [15:0] unit1;
        logic        repl1;
    } t_rec;

endpackage

[rtl/u8u16_ifs.sv]
// stream interfaces of the utf-8 to utf-16 decoder: byte input and code unit output
// no dependencies
interface u8u16_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       final_byte;

    modport source (output valid, output byte_in, output final_byte, input ready);
    modport sink (input valid, input byte_in, input final_byte, output ready);
endinterface

interface u8u16_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        replaced;
    logic        end_of_run;
    logic        end_of_text;

    modport source (output valid, output code_unit, output replaced,
                    output end_of_run, output end_of_text, input ready);
    modport sink (input valid, input code_unit, input replaced,
                  input end_of_run, input end_of_text, output ready);
endinterface

[rtl/utf8_to_utf16_stream_decoder_unit.sv]
// Streaming UTF-8 to UTF-16 decoder for the Basic Multilingual Plane. One byte is accepted per
// clock cycle whenever the record queue has room; the decode state updates in the same cycle,
// so a byte may follow in the very next cycle. Each byte yields zero, one or two code units.
// The output side delivers one code unit per cycle while ready is high, so a byte with two
// results takes two output transactions, and the QUEUE_DEPTH record queue between decode
// and output absorbs such bursts; sustained input rate is one byte per cycle as long as
// results average at most one per byte and the output is not stalled.
// depends on u8u16_pkg, u8u16_ifs, u8u16_front, u8u16_queue, u8u16_back
module utf8_to_utf16_stream_decoder_unit
    import u8u16_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8u16_in_if.sink    i_in,
    u8u16_out_if.source o_out
);

    logic w_push, w_pop, w_full, w_valid;
    t_rec w_rec_in, w_rec_out;

    u8u16_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_rec   (w_rec_in)
    );

    u8u16_queue #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_rec   (w_rec_in),
        .i_pop   (w_pop),
        .o_valid (w_valid),
        .o_full  (w_full),
        .o_rec   (w_rec_out)
    );

    u8u16_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid),
        .i_rec   (w_rec_out),
        .o_pop   (w_pop),
        .o_out   (o_out)
    );

endmodule

[rtl/u8u16_front.sv]
// front end: accepts bytes, keeps the pending sequence state and builds result records
// depends on u8u16_pkg and u8u16_in_if
module u8u16_front
    import u8u16_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    u8u16_in_if.sink    i_in,
    input  logic        i_full,
    output logic        o_push,
    output t_rec        o_rec
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_lead, n_lead;
    logic [7:0]  r_second, n_second;
    logic [2:0]  r_skip, n_skip;

    logic        w_accept;
    logic [7:0]  w_b;
    logic        w_cont;

    // lead decode of the incoming byte
    logic        l_v;
    logic [15:0] l_unit;
    logic        l_repl;
    t_phase      l_phase;
    logic [2:0]  l_skip;
    logic        l_set_lead;

    // result slots in order: pending sequence, new lead, end of text
    logic        a_v, b_v, c_v;
    logic [15:0] a_unit;
    logic        a_repl;
    logic        use_lead;

    assign i_in.ready = !i_full;
    assign w_accept   = i_in.valid && !i_full;
    assign w_b        = i_in.byte_in;
    assign w_cont     = (w_b[7:6] == 2'b10);

    always_comb begin
        l_v        = 1'b0;
        l_unit     = UNDERSCORE;
        l_repl     = 1'b1;
        l_phase    = PH_IDLE;
        l_skip     = 3'd0;
        l_set_lead = 1'b0;
        priority if (!w_b[7]) begin
            l_v    = 1'b1;
            l_unit = {8'h00, w_b};
            l_repl = 1'b0;
        end else if (!w_b[6]) begin
            l_v = 1'b1;
        end else if (!w_b[5]) begin
            l_set_lead = 1'b1;
            l_phase    = PH_TWO;
        end else if (!w_b[4]) begin
            l_set_lead = 1'b1;
            l_phase    = PH_THREE1;
        end else if (w_b[7:1] != 7'h7F) begin
            l_v     = 1'b1;
            l_phase = PH_SKIP;
            priority if (!w_b[3]) begin
                l_skip = 3'd3;
            end else if (!w_b[2]) begin
                l_skip = 3'd4;
            end else begin
                l_skip = 3'd5;
            end
        end else begin
            l_v = 1'b1;
        end
    end

    always_comb begin
        n_phase  = r_phase;
        n_lead   = r_lead;
        n_second = r_second;
        n_skip   = r_skip;
        a_v      = 1'b0;
        a_unit   = UNDERSCORE;
        a_repl   = 1'b1;
        use_lead = 1'b0;

        unique case (r_phase)
            PH_TWO: begin
                a_v = 1'b1;
                if (w_cont) begin
                    n_phase = PH_IDLE;
                    // c0 and c1 leads are overlong
                    if (r_lead[7:1] != 7'h60) begin
                        a_unit = {5'd0, r_lead[4:0], w_b[5:0]};
                        a_repl = 1'b0;
                    end
                end else begin
                    use_lead = 1'b1;
                end
            end
            PH_THREE1: begin
                if (w_cont) begin
                    n_second = w_b;
                    n_phase  = PH_THREE2;
                end else begin
                    a_v      = 1'b1;
                    use_lead = 1'b1;
                end
            end
            PH_THREE2: begin
                a_v = 1'b1;
                if (w_cont) begin
                    n_phase = PH_IDLE;
                    // reject encoded surrogates and overlong e0 forms
                    if (!((r_lead[3:0] == 4'hD) && r_second[5]) &&
                        !((r_lead == 8'hE0) && (r_second[7:5] == 3'b100))) begin
                        a_unit = {r_lead[3:0], r_second[5:0], w_b[5:0]};
                        a_repl = 1'b0;
                    end
                end else begin
                    use_lead = 1'b1;
                end
            end
            PH_SKIP: begin
                if (w_b[7] && (r_skip != 3'd0)) begin
                    n_skip = r_skip - 3'd1;
                    if (r_skip == 3'd1) begin
                        n_phase = PH_IDLE;
                    end
                end else begin
                    n_skip   = 3'd0;
                    use_lead = 1'b1;
                end
            end
            default: begin
                use_lead = 1'b1;
            end
        endcase

        if (use_lead) begin
            n_phase = l_phase;
            if (l_set_lead) begin
                n_lead = w_b;
            end
            if (l_phase == PH_SKIP) begin
                n_skip = l_skip;
            end
        end
        b_v = use_lead && l_v;

        c_v = i_in.final_byte &&
              ((n_phase == PH_TWO) || (n_phase == PH_THREE1) || (n_phase == PH_THREE2));
        if (i_in.final_byte) begin
            n_phase = PH_IDLE;
            n_skip  = 3'd0;
        end

        // keep the first two results of the slots in order
        o_rec.fin   = i_in.final_byte;
        o_rec.unit1 = UNDERSCORE;
        o_rec.repl1 = 1'b1;
        if (a_v) begin
            o_rec.unit0 = a_unit;
            o_rec.repl0 = a_repl;
            o_rec.two   = b_v || c_v;
            if (b_v) begin
                o_rec.unit1 = l_unit;
                o_rec.repl1 = l_repl;
            end
        end else if (b_v) begin
            o_rec.unit0 = l_unit;
            o_rec.repl0 = l_repl;
            o_rec.two   = c_v;
        end else begin
            o_rec.unit0 = UNDERSCORE;
            o_rec.repl0 = 1'b1;
            o_rec.two   = 1'b0;
        end
        o_push = w_accept && (a_v || b_v || c_v);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_lead   <= 8'h00;
            r_second <= 8'h00;
            r_skip   <= 3'd0;
        end else if (w_accept) begin
            r_phase  <= n_phase;
            r_lead   <= n_lead;
            r_second <= n_second;
            r_skip   <= n_skip;
        end
    end

endmodule

[rtl/u8u16_queue.sv]
// short record queue between the decode front end and the output back end
// depends on u8u16_pkg
module u8u16_queue
    import u8u16_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    input  logic i_pop,
    output logic o_valid,
    output logic o_full,
    output t_rec o_rec
);

    localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CntW = $clog2(DEPTH + 1);

    t_rec            r_mem [DEPTH];
    logic [PtrW-1:0] r_wr, n_wr;
    logic [PtrW-1:0] r_rd, n_rd;
    logic [CntW-1:0] r_cnt, n_cnt;

    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CntW'(DEPTH));
    assign o_rec   = r_mem[r_rd];

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (i_push) begin
            n_wr = (r_wr == PtrW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PtrW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

endmodule

[rtl/u8u16_back.sv]
// back end: presents queued records as code unit transactions, two transactions for a pair
// depends on u8u16_pkg and u8u16_out_if
module u8u16_back
    import u8u16_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_rec        i_rec,
    output logic        o_pop,
    u8u16_out_if.source o_out
);

    logic r_sub, n_sub;
    logic w_last;
    logic w_take;

    assign w_last = !i_rec.two || r_sub;
    assign w_take = i_valid && o_out.ready;

    assign o_out.valid       = i_valid;
    assign o_out.code_unit   = r_sub ? i_rec.unit1 : i_rec.unit0;
    assign o_out.replaced    = r_sub ? i_rec.repl1 : i_rec.repl0;
    assign o_out.end_of_run  = w_last;
    assign o_out.end_of_text = w_last && i_rec.fin;

    assign o_pop = w_take && w_last;

    always_comb begin
        n_sub = r_sub;
        if (w_take) begin
            n_sub = !w_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sub <= 1'b0;
        end else begin
            r_sub <= n_sub;
        end
    end

endmodule

[rtl/u8u16_checker.sv]
// port-level checker for the utf-8 to utf-16 decoder, bound to the top level
// depends on utf8_to_utf16_stream_decoder_unit_assert.svh and the top level
`include "utf8_to_utf16_stream_decoder_unit_assert.svh"

module u8u16_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [15:0] i_code_unit,
    input logic        i_replaced,
    input logic        i_end_of_run,
    input logic        i_end_of_text
);

    // a replaced transaction always carries the underscore
    `U8U16_ASSERT_NOW(a_repl_unit, i_clk, i_rst_n, i_out_valid && i_replaced, i_code_unit == 16'h005F)
    // end of text is only on the last unit of a byte
    `U8U16_ASSERT_NOW(a_eot_eor, i_clk, i_rst_n, i_out_valid && i_end_of_text, i_end_of_run)
    // decoded units never fall in the surrogate range
    `U8U16_ASSERT_NOW(a_no_surr, i_clk, i_rst_n, i_out_valid && !i_replaced, i_code_unit[15:11] != 5'b11011)
    // a stalled transaction keeps its unit
    `U8U16_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_code_unit))

endmodule

bind utf8_to_utf16_stream_decoder_unit u8u16_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_code_unit   (o_out.code_unit),
    .i_replaced    (o_out.replaced),
    .i_end_of_run  (o_out.end_of_run),
    .i_end_of_text (o_out.end_of_text)
);

[tb/sv/utf8_to_utf16_stream_decoder_unit_test.sv]
// self-checking testbench of the utf-8 to utf-16 stream decoder: directed byte table, then random text
// depends on u8u16_pkg, u8u16_ifs and utf8_to_utf16_stream_decoder_unit
module utf8_to_utf16_stream_decoder_unit_test
    import u8u16_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] b;
        logic       fin;
    } t_byte_item;

    typedef struct packed {
        logic [15:0] unit;
        logic        repl;
        logic        eor;
        logic        eot;
    } t_unit_exp;

    // directed row: typed rows carry their own expected units, the rest use the decoder model
    typedef struct packed {
        logic [7:0]  b;
        logic        fin;
        logic        typed;
        logic [1:0]  n;
        logic [15:0] u0;
        logic        r0;
        logic [15:0] u1;
        logic        r1;
    } t_row;

    localparam int HOLD_CYCLES = 400;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    u8u16_in_if  byte_if ();
    u8u16_out_if unit_if ();

    utf8_to_utf16_stream_decoder_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (byte_if),
        .o_out   (unit_if)
    );

    always #5 i_clk = ~i_clk;

    t_row dir_tab [26] = '{
        '{8'h00, 1'b0, 1'b1, 2'd1, 16'h0000,   1'b0, 16'h0000, 1'b0},
        '{8'h7F, 1'b0, 1'b1, 2'd1, 16'h007F,   1'b0, 16'h0000, 1'b0},
        '{8'h80, 1'b0, 1'b1, 2'd1, UNDERSCORE, 1'b1, 16'h0000, 1'b0},
        '{8'hFE, 1'b0, 1'b1, 2'd1, UNDERSCORE, 1'b1, 16'h0000, 1'b0},
        '{8'hFF, 1'b0, 1'b1, 2'd1, UNDERSCORE, 1'b1, 16'h0000, 1'b0},
        '{8'hC3, 1'b0, 1'b1, 2'd0, 16'h0000,   1'b0, 16'h0000, 1'b0},
        '{8'hA9, 1'b0, 1'b0, 2'd0, 16'h0000,   1'b0, 16'h0000, 1'b0},
        // overlong two-byte form
        '{8'hC1, 1'b0, 1'b1, 2'd0, 16'h0000,   1'b0, 16'h0000, 1'b0},
        '{8'hBF, 1'b0, 1'b1, 2'd1, UNDERSCORE, 1'b1, 16'h0000, 1'b0},
        // overlong three-byte form
        '{8'hE0, 1'b0, 1'b1, 2'd0, 16'h0000,   1'b0, 16'h0000, 1'b0},
        '{8'h80, 1'b0, 1'b1, 2'd0, 16'h0000,   1'b0, 16'h0000, 1'b0},
        '{8'h80, 1'b0, 1'b1, 2'd1, UNDERSCORE, 1'b1, 16'h0000, 1'b0},
        // encoded surrogate
        '{8'hED, 1'b0, 1'b1, 2'd0, 16'h0000,   1'b0, 16'h0000, 1'b0},
        '{8'hA0, 1'b0, 1'b1, 2'd0, 16'h0000,   1'b0, 16'h0000, 1'b0},
        '{8'h80, 1'b0, 1'b1, 2'd1, UNDERSCORE, 1'b1, 16'h0000, 1'b0},
        '{8'hEF, 1'b0, 1'b0, 2'd0, 16'h0000,   1'b0, 16'h0000, 1'b0},
        '{8'hBF, 1'b0, 1'b0, 2'd0, 16'h0000,   1'b0, 16'h0000, 1'b0},
        '{8'hBF, 1'b0, 1'b1, 2'd1, 16'hFFFF,   1'b0, 16'h0000, 1'b0},
        // bad continuation gives two units
        '{8'hC3, 1'b0, 1'b1, 2'd0, 16'h0000,   1'b0, 16'h0000, 1'b0},
        '{8'h41, 1'b0, 1'b1, 2'd2, UNDERSCORE, 1'b1, 16'h0041, 1'b0},
        // four-byte lead, swallowing cut short by ascii
        '{8'hF0, 1'b0, 1'b1, 2'd1, UNDERSCORE, 1'b1, 16'h0000, 1'b0},
        '{8'h80, 1'b0, 1'b1, 2'd0, 16'h0000,   1'b0, 16'h0000, 1'b0},
        '{8'h41, 1'b0, 1'b1, 2'd1, 16'h0041,   1'b0, 16'h0000, 1'b0},
        // final byte with a partial sequence pending
        '{8'hE4, 1'b1, 1'b1, 2'd1, UNDERSCORE, 1'b1, 16'h0000, 1'b0},
        // final byte swallowed, no end of text
        '{8'hFD, 1'b0, 1'b1, 2'd1, UNDERSCORE, 1'b1, 16'h0000, 1'b0},
        '{8'h80, 1'b1, 1'b1, 2'd0, 16'h0000,   1'b0, 16'h0000, 1'b0}
    };

    // decoder model state
    t_phase      dec_phase  = PH_IDLE;
    logic [7:0]  dec_lead   = 8'h00;
    logic [7:0]  dec_second = 8'h00;
    logic [2:0]  dec_skip   = 3'd0;
    logic [15:0] step_unit [2];
    logic        step_repl [2];
    int          step_n;

    t_unit_exp  unit_q [$];
    t_byte_item stim_q [$];
    int         mism_count  = 0;
    int         tx_idle_pct = 26;
    int         rx_idle_pct = 63;
    logic       rx_hold     = 1'b0;
    t_unit_exp  got_unit;
    t_unit_exp  want_unit;

    function automatic void emit(input logic [15:0] u, input logic r);
        if (step_n < 2) begin
            step_unit[step_n] = u;
            step_repl[step_n] = r;
            step_n++;
        end
    endfunction

    function automatic void start_seq(input logic [7:0] b);
        dec_phase = PH_IDLE;
        if (b < 8'h80) begin
            emit({8'h00, b}, 1'b0);
        end else if (b < 8'hC0) begin
            emit(UNDERSCORE, 1'b1);
        end else if (b < 8'hE0) begin
            dec_lead  = b;
            dec_phase = PH_TWO;
        end else if (b < 8'hF0) begin
            dec_lead  = b;
            dec_phase = PH_THREE1;
        end else if (b < 8'hFE) begin
            emit(UNDERSCORE, 1'b1);
            dec_skip  = (b < 8'hF8) ? 3'd3 : ((b < 8'hFC) ? 3'd4 : 3'd5);
            dec_phase = PH_SKIP;
        end else begin
            emit(UNDERSCORE, 1'b1);
        end
    endfunction

    function automatic void decode_byte(input logic [7:0] b, input logic fin);
        logic surrogate;
        logic overlong;
        step_n = 0;
        unique case (dec_phase)
            PH_TWO: begin
                if (b[7:6] != 2'b10) begin
                    emit(UNDERSCORE, 1'b1);
                    start_seq(b);
                end else begin
                    dec_phase = PH_IDLE;
                    if (dec_lead[7:1] == 7'b1100000)
                        emit(UNDERSCORE, 1'b1);
                    else
                        emit({5'd0, dec_lead[4:0], b[5:0]}, 1'b0);
                end
            end
            PH_THREE1: begin
                if (b[7:6] != 2'b10) begin
                    emit(UNDERSCORE, 1'b1);
                    start_seq(b);
                end else begin
                    dec_second = b;
                    dec_phase  = PH_THREE2;
                end
            end
            PH_THREE2: begin
                if (b[7:6] != 2'b10) begin
                    emit(UNDERSCORE, 1'b1);
                    start_seq(b);
                end else begin
                    // ed a0..bf is a surrogate, e0 80..9f is overlong
                    surrogate = (dec_lead[3:0] == 4'hD) && dec_second[5];
                    overlong  = (dec_lead == 8'hE0) && (dec_second[7:5] == 3'b100);
                    dec_phase = PH_IDLE;
                    if (surrogate || overlong)
                        emit(UNDERSCORE, 1'b1);
                    else
                        emit({dec_lead[3:0], dec_second[5:0], b[5:0]}, 1'b0);
                end
            end
            PH_SKIP: begin
                if (b[7] && dec_skip != 3'd0) begin
                    dec_skip = dec_skip - 3'd1;
                    if (dec_skip == 3'd0)
                        dec_phase = PH_IDLE;
                end else begin
                    dec_skip = 3'd0;
                    start_seq(b);
                end
            end
            default: begin
                start_seq(b);
            end
        endcase
        if (fin) begin
            if (dec_phase == PH_TWO || dec_phase == PH_THREE1 || dec_phase == PH_THREE2)
                emit(UNDERSCORE, 1'b1);
            dec_phase = PH_IDLE;
            dec_skip  = 3'd0;
        end
    endfunction

    function automatic void expect_units(input int n, input logic [15:0] u0, input logic r0,
                                         input logic [15:0] u1, input logic r1,
                                         input logic fin);
        if (n >= 1)
            unit_q.push_back('{u0, r0, n == 1, fin && n == 1});
        if (n >= 2)
            unit_q.push_back('{u1, r1, 1'b1, fin});
    endfunction

    function automatic logic [7:0] rand_cont();
        return {2'b10, 6'($urandom_range(0, 63))};
    endfunction

    // random text: mostly well-formed sequences, some broken ones and noise
    task automatic gen_text(input int count);
        logic [7:0] seq [$];
        int         kind;
        int         len;
        logic [7:0] lead;
        logic       fin_last;
        while (count > 0) begin
            seq.delete();
            kind = $urandom_range(0, 99);
            if (kind < 20) begin
                seq.push_back(8'($urandom_range(0, 127)));
            end else if (kind < 40) begin
                seq.push_back(8'($urandom_range(8'hC2, 8'hDF)));
                seq.push_back(rand_cont());
            end else if (kind < 58) begin
                seq.push_back(8'($urandom_range(8'hE0, 8'hEF)));
                seq.push_back(rand_cont());
                seq.push_back(rand_cont());
            end else if (kind < 64) begin
                seq.push_back(8'($urandom_range(8'hC0, 8'hC1)));
                seq.push_back(rand_cont());
            end else if (kind < 74) begin
                seq.push_back(8'($urandom_range(8'hF0, 8'hFD)));
                len = $urandom_range(0, 6);
                repeat (len) seq.push_back(rand_cont());
            end else if (kind < 86) begin
                // truncated sequence followed by any byte
                lead = 8'($urandom_range(8'hC0, 8'hEF));
                seq.push_back(lead);
                if (lead >= 8'hE0 && $urandom_range(0, 1) == 1)
                    seq.push_back(rand_cont());
                seq.push_back(8'($urandom_range(0, 255)));
            end else begin
                seq.push_back(8'($urandom_range(0, 255)));
            end
            fin_last = ($urandom_range(0, 11) == 0);
            foreach (seq[k]) begin
                stim_q.push_back('{seq[k], fin_last && (k == seq.size() - 1)});
                count--;
            end
        end
    endtask

    task automatic send_byte(input t_byte_item it);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            byte_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        byte_if.valid      <= 1'b1;
        byte_if.byte_in    <= it.b;
        byte_if.final_byte <= it.fin;
        do @(posedge i_clk); while (!byte_if.ready);
    endtask

    task automatic send_stream(input int hold_at);
        foreach (stim_q[i]) begin
            if (i == hold_at) begin
                fork
                    begin
                        rx_hold <= 1'b1;
                        repeat (HOLD_CYCLES) @(posedge i_clk);
                        rx_hold <= 1'b0;
                    end
                join_none
            end
            send_byte(stim_q[i]);
            decode_byte(stim_q[i].b, stim_q[i].fin);
            expect_units(step_n, step_unit[0], step_repl[0], step_unit[1], step_repl[1],
                         stim_q[i].fin);
        end
        stim_q.delete();
    endtask

    // sender pauses until every pending code unit has come out
    task automatic drain();
        byte_if.valid <= 1'b0;
        wait (unit_q.size() == 0);
        @(posedge i_clk);
    endtask

    function automatic void note_mismatch(input string what, input t_unit_exp want,
                                          input t_unit_exp got);
        mism_count++;
        if (mism_count <= 10)
            $display("%0t %s: expected unit %h repl %b eor %b eot %b, ",
                     $realtime, what, want.unit, want.repl, want.eor, want.eot,
                     "got unit %h repl %b eor %b eot %b",
                     got.unit, got.repl, got.eor, got.eot);
    endfunction

    always @(posedge i_clk) begin
        unit_if.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && unit_if.valid && unit_if.ready) begin
            got_unit = '{unit_if.code_unit, unit_if.replaced, unit_if.end_of_run,
                         unit_if.end_of_text};
            if (unit_q.size() == 0) begin
                note_mismatch("unexpected transaction", '0, got_unit);
            end else begin
                want_unit = unit_q.pop_front();
                if (got_unit.unit !== want_unit.unit || got_unit.repl !== want_unit.repl ||
                    got_unit.eor !== want_unit.eor || got_unit.eot !== want_unit.eot)
                    note_mismatch("code unit mismatch", want_unit, got_unit);
            end
        end
    end

    initial begin
        byte_if.valid      = 1'b0;
        byte_if.byte_in    = 8'h00;
        byte_if.final_byte = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_tab[i]) begin
            send_byte('{dir_tab[i].b, dir_tab[i].fin});
            decode_byte(dir_tab[i].b, dir_tab[i].fin);
            if (dir_tab[i].typed)
                expect_units(dir_tab[i].n, dir_tab[i].u0, dir_tab[i].r0,
                             dir_tab[i].u1, dir_tab[i].r1, dir_tab[i].fin);
            else
                expect_units(step_n, step_unit[0], step_repl[0], step_unit[1], step_repl[1],
                             dir_tab[i].fin);
        end
        drain();

        gen_text(630);
        send_stream(120);
        drain();

        tx_idle_pct = 63;
        rx_idle_pct <= 26;
        gen_text(630);
        send_stream(-1);
        drain();

        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        gen_text(630);
        send_stream(-1);

        byte_if.valid <= 1'b0;
        wait (unit_q.size() == 0);
        repeat (20) @(posedge i_clk);
        if (mism_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
